// ===== rtl/csu8_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and UTF-8 helpers of the C string escape decoder.
package csu8_pkg;

  localparam int NumSlots = 5;

  // Error codes carried on every result
  localparam logic [2:0] ErrNone    = 3'd0;
  localparam logic [2:0] ErrTrunc   = 3'd1;
  localparam logic [2:0] ErrUnknown = 3'd2;
  localparam logic [2:0] ErrUtf8    = 3'd3;
  localparam logic [2:0] ErrRange   = 3'd4;

  typedef enum logic [3:0] {
    ModePlain  = 4'b0001,
    ModeEsc    = 4'b0010,
    ModeDigits = 4'b0100,
    ModeUtf8   = 4'b1000
  } mode_t;

  // One result word
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       eos;
    logic [2:0] err;
  } res_t;

  // All results of one input word, slot 0 leaves first
  typedef struct packed {
    logic [2:0]                cnt;
    res_t [NumSlots-1:0]       slot;
  } burst_t;

  // Encoded code point: 1 to 4 bytes
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] data;
    logic [2:0]      err;
  } enc_t;

  function automatic enc_t utf8_encode(logic [31:0] cp, logic [2:0] err);
    enc_t        e;
    logic [20:0] c;
    e = '0;
    e.err = err;
    if (cp[31:21] != 11'd0 && err == ErrNone) begin
      e.err = ErrRange;
    end
    c = cp[20:0];
    if (c < 21'h80) begin
      e.cnt     = 3'd1;
      e.data[0] = {1'b0, c[6:0]};
    end else if (c < 21'h800) begin
      e.cnt     = 3'd2;
      e.data[0] = {3'b110, c[10:6]};
      e.data[1] = {2'b10, c[5:0]};
    end else if (c < 21'h10000) begin
      e.cnt     = 3'd3;
      e.data[0] = {4'b1110, c[15:12]};
      e.data[1] = {2'b10, c[11:6]};
      e.data[2] = {2'b10, c[5:0]};
    end else begin
      e.cnt     = 3'd4;
      e.data[0] = {5'b11110, c[20:18]};
      e.data[1] = {2'b10, c[17:12]};
      e.data[2] = {2'b10, c[11:6]};
      e.data[3] = {2'b10, c[5:0]};
    end
    return e;
  endfunction

  // {is_digit, value}; octal digits only unless hex is set
  function automatic logic [4:0] digit_val(logic [7:0] b, logic hex);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h37) begin
      r = {1'b1, b[3:0]};
    end else if (hex) begin
      if (b >= 8'h38 && b <= 8'h39) begin
        r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
        r = {1'b1, b[3:0] + 4'd9};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/csu8_decode.sv =====
`timescale 1ns / 1ps
// Input register, scan state and one-pass decode of a source byte into results.
module csu8_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_text,
  input  logic              buf_room,
  output logic              buf_push,
  output csu8_pkg::burst_t  burst
);
  import csu8_pkg::*;

  logic        in_full_r;
  logic [7:0]  byte_r;
  logic        eot_r;

  mode_t       mode_r, mode_nxt;
  logic [3:0]  dl_r, dl_nxt;
  logic        hex_r, hex_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  cl_r, cl_nxt;
  logic        pend_r, pend_nxt;

  logic [4:0]  dig;
  logic        plain;
  logic        e1_v;
  logic [31:0] e1_cp;
  logic [2:0]  e1_err;
  logic        e2_v;
  logic [7:0]  e2_data;
  logic [2:0]  e2_err;
  logic        e3_v;
  logic        e3_mark;
  logic [31:0] e3_cp;
  logic [2:0]  e3_err;
  enc_t        e1_enc, e3_enc;
  logic [2:0]  n1, n2, n3;
  logic [3:0]  n_all;
  logic        fire;

  assign dig = digit_val(byte_r, hex_r);

  always_comb begin
    mode_nxt = mode_r;
    dl_nxt   = dl_r;
    hex_nxt  = hex_r;
    acc_nxt  = acc_r;
    cl_nxt   = cl_r;
    pend_nxt = pend_r;
    plain    = 1'b0;
    e1_v     = 1'b0;
    e1_cp    = '0;
    e1_err   = ErrNone;
    e2_v     = 1'b0;
    e2_data  = '0;
    e2_err   = ErrNone;
    e3_v     = 1'b0;
    e3_mark  = 1'b0;
    e3_cp    = '0;
    e3_err   = ErrNone;

    unique case (mode_r)
      ModeDigits: begin
        if (dig[4]) begin
          acc_nxt = hex_r ? {acc_r[27:0], dig[3:0]} : {acc_r[28:0], dig[2:0]};
          dl_nxt  = (dl_r != 4'd0) ? dl_r - 4'd1 : dl_r;
          if (dl_nxt == 4'd0) begin
            e1_v     = 1'b1;
            e1_cp    = acc_nxt;
            mode_nxt = ModePlain;
          end
        end else begin
          // non-digit ends the escape; short hex is an error, short octal is not
          e1_v     = 1'b1;
          e1_cp    = acc_r;
          e1_err   = hex_r ? ErrTrunc : ErrNone;
          mode_nxt = ModePlain;
          plain    = 1'b1;
        end
      end
      ModeUtf8: begin
        if (byte_r[7:6] == 2'b10) begin
          acc_nxt = {acc_r[25:0], byte_r[5:0]};
          cl_nxt  = (cl_r != 2'd0) ? cl_r - 2'd1 : cl_r;
          if (cl_nxt == 2'd0) begin
            e1_v     = 1'b1;
            e1_cp    = acc_nxt;
            e1_err   = pend_r ? ErrUnknown : ErrNone;
            pend_nxt = 1'b0;
            mode_nxt = ModePlain;
          end
        end else begin
          e1_v     = 1'b1;
          e1_err   = ErrUtf8;
          pend_nxt = 1'b0;
          cl_nxt   = 2'd0;
          mode_nxt = ModePlain;
          plain    = 1'b1;
        end
      end
      ModeEsc: begin
        mode_nxt = ModePlain;
        unique case (byte_r)
          8'h61: begin e1_v = 1'b1; e1_cp = 32'h07; end  // \a
          8'h62: begin e1_v = 1'b1; e1_cp = 32'h08; end  // \b
          8'h66: begin e1_v = 1'b1; e1_cp = 32'h0C; end  // \f
          8'h6E: begin e1_v = 1'b1; e1_cp = 32'h0A; end  // \n
          8'h72: begin e1_v = 1'b1; e1_cp = 32'h0D; end  // \r
          8'h74: begin e1_v = 1'b1; e1_cp = 32'h09; end  // \t
          8'h76: begin e1_v = 1'b1; e1_cp = 32'h0B; end  // \v
          8'h27, 8'h22, 8'h3F, 8'h5C: begin
            e1_v  = 1'b1;
            e1_cp = {24'd0, byte_r};
          end
          8'h78: begin mode_nxt = ModeDigits; hex_nxt = 1'b1; dl_nxt = 4'd2; acc_nxt = '0; end
          8'h75: begin mode_nxt = ModeDigits; hex_nxt = 1'b1; dl_nxt = 4'd4; acc_nxt = '0; end
          8'h55: begin mode_nxt = ModeDigits; hex_nxt = 1'b1; dl_nxt = 4'd8; acc_nxt = '0; end
          default: begin
            if (byte_r[7:3] == 5'b00110) begin
              mode_nxt = ModeDigits;
              hex_nxt  = 1'b0;
              dl_nxt   = 4'd2;
              acc_nxt  = {29'd0, byte_r[2:0]};
            end else if (!byte_r[7]) begin
              e1_v   = 1'b1;
              e1_cp  = {24'd0, byte_r};
              e1_err = ErrUnknown;
            end else begin
              pend_nxt = 1'b1;
              plain    = 1'b1;
            end
          end
        endcase
      end
      ModePlain: plain = 1'b1;
      default:   plain = 1'b1;
    endcase

    if (plain) begin
      if (byte_r == 8'h5C) begin
        mode_nxt = ModeEsc;
      end else if (!byte_r[7]) begin
        e2_v    = 1'b1;
        e2_data = byte_r;
      end else if (byte_r[7:5] == 3'b110) begin
        acc_nxt  = {27'd0, byte_r[4:0]};
        cl_nxt   = 2'd1;
        mode_nxt = ModeUtf8;
      end else if (byte_r[7:4] == 4'b1110) begin
        acc_nxt  = {28'd0, byte_r[3:0]};
        cl_nxt   = 2'd2;
        mode_nxt = ModeUtf8;
      end else if (byte_r[7:3] == 5'b11110) begin
        acc_nxt  = {29'd0, byte_r[2:0]};
        cl_nxt   = 2'd3;
        mode_nxt = ModeUtf8;
      end else begin
        e2_v     = 1'b1;
        e2_err   = ErrUtf8;
        pend_nxt = 1'b0;
      end
    end

    if (eot_r) begin
      // flush whatever construct is open, then drop back to reset state
      unique case (mode_nxt)
        ModeEsc: begin
          e3_v    = 1'b1;
          e3_mark = 1'b1;
          e3_err  = ErrTrunc;
        end
        ModeDigits: begin
          e3_v   = 1'b1;
          e3_cp  = acc_nxt;
          e3_err = hex_nxt ? ErrTrunc : ErrNone;
        end
        ModeUtf8: begin
          e3_v   = 1'b1;
          e3_err = ErrUtf8;
        end
        default: begin
          if (!e1_v && !e2_v) begin
            e3_v    = 1'b1;
            e3_mark = 1'b1;
          end
        end
      endcase
      mode_nxt = ModePlain;
      dl_nxt   = '0;
      hex_nxt  = 1'b0;
      acc_nxt  = '0;
      cl_nxt   = '0;
      pend_nxt = 1'b0;
    end
  end

  assign e1_enc = utf8_encode(e1_cp, e1_err);
  assign e3_enc = utf8_encode(e3_cp, e3_err);

  assign n1    = e1_v ? e1_enc.cnt : 3'd0;
  assign n2    = e2_v ? 3'd1 : 3'd0;
  assign n3    = e3_v ? e3_enc.cnt : 3'd0;
  assign n_all = 4'(n1) + 4'(n2) + 4'(n3);

  // Pack the three emitters into the result slots in order
  always_comb begin : pack
    logic [2:0] kk;
    logic [2:0] jj;
    burst.cnt = (n_all > 4'(NumSlots)) ? 3'(NumSlots) : n_all[2:0];
    for (int k = 0; k < NumSlots; k++) begin
      kk = 3'(k);
      jj = kk - n1 - n2;
      if (kk < n1) begin
        burst.slot[k].data  = e1_enc.data[kk[1:0]];
        burst.slot[k].valid = 1'b1;
        burst.slot[k].err   = e1_enc.err;
      end else if (kk < n1 + n2) begin
        burst.slot[k].data  = e2_data;
        burst.slot[k].valid = 1'b1;
        burst.slot[k].err   = e2_err;
      end else begin
        burst.slot[k].data  = e3_enc.data[jj[1:0]];
        burst.slot[k].valid = !e3_mark;
        burst.slot[k].err   = e3_enc.err;
      end
      burst.slot[k].last = (kk == burst.cnt - 3'd1);
      burst.slot[k].eos  = (kk == burst.cnt - 3'd1) && eot_r;
    end
  end

  assign fire     = in_full_r && (buf_room || burst.cnt == 3'd0);
  assign buf_push = fire && burst.cnt != 3'd0;
  assign in_ready = !in_full_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      mode_r    <= ModePlain;
      dl_r      <= '0;
      hex_r     <= 1'b0;
      acc_r     <= '0;
      cl_r      <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        in_full_r <= in_valid;
      end
      if (fire) begin
        mode_r <= mode_nxt;
        dl_r   <= dl_nxt;
        hex_r  <= hex_nxt;
        acc_r  <= acc_nxt;
        cl_r   <= cl_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      eot_r  <= in_end_of_text;
    end
  end

endmodule

// ===== rtl/csu8_burst.sv =====
`timescale 1ns / 1ps
// Result register: holds the words of one decoded byte and shifts them out.
module csu8_burst (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              buf_push,
  input  csu8_pkg::burst_t  burst,
  output logic              buf_room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_run_last,
  output logic              out_end_of_string,
  output logic [2:0]        out_error_code
);
  import csu8_pkg::*;

  logic [2:0]          cnt_r;
  res_t [NumSlots-1:0] slot_r;
  logic                pop;

  assign out_valid = cnt_r != 3'd0;
  assign pop       = out_valid && out_ready;
  assign buf_room  = cnt_r == 3'd0 || (cnt_r == 3'd1 && out_ready);

  assign out_byte          = slot_r[0].data;
  assign out_byte_valid    = slot_r[0].valid;
  assign out_run_last      = slot_r[0].last;
  assign out_end_of_string = slot_r[0].eos;
  assign out_error_code    = slot_r[0].err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (buf_push) begin
      cnt_r <= burst.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_push) begin
      slot_r <= burst.slot;
    end else if (pop) begin
      for (int i = 0; i < NumSlots - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(NumSlots))
    else $error("result count beyond slot count");

  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_string |-> out_run_last)
    else $error("end of string not on last word of run");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0 && out_run_last)
    else $error("marker word malformed");

  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("run cut short");

endmodule

// ===== rtl/c_string_escape_to_utf8.sv =====
`timescale 1ns / 1ps
// Top level of the C string literal escape decoder with UTF-8 output.
//
// Input channel (in_valid/in_ready): one byte of a C string literal body per
// word, quotes already stripped; in_end_of_text marks the final byte.
// Output channel (out_valid/out_ready): one UTF-8 byte per word, with
// out_byte_valid low on marker words, out_run_last on the last word caused by
// an input byte, out_end_of_string on the last word of the literal, and
// out_error_code (truncated escape, unknown escape, bad UTF-8, too large).
// An accepted byte is held in the input register; its run of result words
// loads into the result register once that has room. Each byte makes 0 to 5
// result words; the single output word per cycle, while out_ready is high,
// sets the rate, so the block takes one byte per cycle while bytes make at
// most one word each, and a byte with more words holds the next byte back
// until the last word of its run leaves. Bytes that make no word pass at one
// per cycle even while an earlier run drains.
// Reset (rst_n low, synchronous) empties both registers and returns the scan
// to plain text. When the receiver stalls, the result register holds its
// word, the decoder waits with a byte that makes words, and in_ready falls.
module c_string_escape_to_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_end_of_string,
  output logic [2:0] out_error_code
);
  import csu8_pkg::*;

  // decoded run of the byte in the input register
  burst_t burst;
  // result register can take a run this cycle
  logic   buf_room;
  // load the run into the result register
  logic   buf_push;

  csu8_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .buf_room       (buf_room),
    .buf_push       (buf_push),
    .burst          (burst)
  );

  csu8_burst u_burst (
    .clk               (clk),
    .rst_n             (rst_n),
    .buf_push          (buf_push),
    .burst             (burst),
    .buf_room          (buf_room),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_run_last      (out_run_last),
    .out_end_of_string (out_end_of_string),
    .out_error_code    (out_error_code)
  );

endmodule

// ===== tb/c_string_escape_to_utf8_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the C string escape decoder with UTF-8 output.
module c_string_escape_to_utf8_test;
  import csu8_pkg::*;

  // Characters the escape decoder reacts to
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChHex2      = 8'h78;  // x
  localparam logic [7:0] ChHex4      = 8'h75;  // u
  localparam logic [7:0] ChHex8      = 8'h55;  // U

  localparam int StallLimit = 4000;  // cycles with no word moved on either side
  localparam int DrainAt0   = 40;    // sender waits for an empty pipe before these
  localparam int DrainAt1   = 380;
  localparam int HoldAt     = 150;   // receiver holds off once this many bytes went in
  localparam int HoldLen    = 120;
  localparam int QuietLo    = 250;   // no idling on either side in this window
  localparam int QuietHi    = 330;
  localparam int PrintCap   = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_run_last;
  logic       out_end_of_string;
  logic [2:0] out_error_code;

  c_string_escape_to_utf8 uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_end_of_text    (in_end_of_text),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_run_last      (out_run_last),
    .out_end_of_string (out_end_of_string),
    .out_error_code    (out_error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Source bytes still to be offered, one entry per word
  logic [7:0] src_bytes[$];
  logic       src_eot[$];
  logic       src_drain[$];
  logic [7:0] tok[$];

  // Decoded UTF-8 words still owed by the block, oldest first
  res_t utf8_words[$];
  res_t burst[$];
  res_t want_word;

  // Own copy of the scan state
  mode_t       scan_q;
  logic [3:0]  digits_q;
  logic        hex_q;
  logic [31:0] accum_q;
  logic [1:0]  cont_q;
  logic [2:0]  perr_q;

  logic        offering = 1'b0;
  logic        moved;
  logic        go;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned in_count = 0;
  int unsigned out_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_count = 0;

  wire quiet = (in_count >= QuietLo) && (in_count < QuietHi);

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    scan_q   = ModePlain;
    digits_q = 4'd0;
    hex_q    = 1'b0;
    accum_q  = 32'd0;
    cont_q   = 2'd0;
    perr_q   = ErrNone;
  endfunction

  // Digit value in the current radix, -1 if the byte is not a digit
  function automatic int digit_of(logic [7:0] b, logic hex);
    if (b >= 8'h30 && b <= 8'h37) return b - 8'h30;
    if (!hex) return -1;
    if (b >= 8'h38 && b <= 8'h39) return b - 8'h30;
    if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
    return -1;
  endfunction

  function automatic void add_word(logic [7:0] d, logic v, logic [2:0] e);
    res_t r;
    if (burst.size() >= NumSlots) return;
    r.data  = d;
    r.valid = v;
    r.last  = 1'b0;
    r.eos   = 1'b0;
    r.err   = e;
    burst.push_back(r);
  endfunction

  // Emit a code point as 1 to 4 UTF-8 bytes; cut values beyond 21 bits
  function automatic void encode_point(logic [31:0] cp, logic [2:0] e);
    logic [2:0]  ee;
    logic [20:0] c;
    ee = e;
    if (cp > 32'h1FFFFF && ee == ErrNone) ee = ErrRange;
    c = cp[20:0];
    if (c < 21'h80) begin
      add_word({1'b0, c[6:0]}, 1'b1, ee);
    end else if (c < 21'h800) begin
      add_word({3'b110, c[10:6]}, 1'b1, ee);
      add_word({2'b10, c[5:0]}, 1'b1, ee);
    end else if (c < 21'h10000) begin
      add_word({4'b1110, c[15:12]}, 1'b1, ee);
      add_word({2'b10, c[11:6]}, 1'b1, ee);
      add_word({2'b10, c[5:0]}, 1'b1, ee);
    end else begin
      add_word({5'b11110, c[20:18]}, 1'b1, ee);
      add_word({2'b10, c[17:12]}, 1'b1, ee);
      add_word({2'b10, c[11:6]}, 1'b1, ee);
      add_word({2'b10, c[5:0]}, 1'b1, ee);
    end
  endfunction

  function automatic void enter_digits(logic hex, logic [3:0] count, logic [31:0] start);
    scan_q   = ModeDigits;
    hex_q    = hex;
    digits_q = count;
    accum_q  = start;
  endfunction

  // A byte seen in plain text: backslash, ASCII, or a UTF-8 lead
  function automatic void take_plain(logic [7:0] b);
    if (b == ChBackslash) begin
      scan_q = ModeEsc;
      return;
    end
    if (!b[7]) begin
      encode_point({24'd0, b}, ErrNone);
      return;
    end
    if (b[7:5] == 3'b110) begin
      accum_q = {27'd0, b[4:0]};
      cont_q  = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      accum_q = {28'd0, b[3:0]};
      cont_q  = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      accum_q = {29'd0, b[2:0]};
      cont_q  = 2'd3;
    end else begin
      // lone continuation or 0xF8..0xFF lead
      encode_point(32'd0, ErrUtf8);
      perr_q = ErrNone;
      return;
    end
    scan_q = ModeUtf8;
  endfunction

  // Advance the scan by one accepted byte and queue the words it causes
  function automatic void predict_word(logic [7:0] b, logic eot);
    int   d;
    logic to_plain;
    res_t r;
    burst.delete();
    to_plain = 1'b0;
    case (scan_q)
      ModeDigits: begin
        d = digit_of(b, hex_q);
        if (d >= 0) begin
          accum_q = hex_q ? {accum_q[27:0], d[3:0]} : {accum_q[28:0], d[2:0]};
          if (digits_q != 4'd0) digits_q = digits_q - 4'd1;
          if (digits_q == 4'd0) begin
            encode_point(accum_q, ErrNone);
            scan_q = ModePlain;
          end
        end else begin
          // a short hex escape is an error, a short octal one is not
          encode_point(accum_q, hex_q ? ErrTrunc : ErrNone);
          scan_q   = ModePlain;
          to_plain = 1'b1;
        end
      end
      ModeUtf8: begin
        if (b[7:6] == 2'b10) begin
          accum_q = {accum_q[25:0], b[5:0]};
          if (cont_q != 2'd0) cont_q = cont_q - 2'd1;
          if (cont_q == 2'd0) begin
            encode_point(accum_q, perr_q);
            perr_q = ErrNone;
            scan_q = ModePlain;
          end
        end else begin
          encode_point(32'd0, ErrUtf8);
          perr_q   = ErrNone;
          cont_q   = 2'd0;
          scan_q   = ModePlain;
          to_plain = 1'b1;
        end
      end
      ModeEsc: begin
        scan_q = ModePlain;
        case (b)
          8'h61: encode_point(32'h07, ErrNone);  // \a
          8'h62: encode_point(32'h08, ErrNone);  // \b
          8'h66: encode_point(32'h0C, ErrNone);  // \f
          8'h6E: encode_point(32'h0A, ErrNone);  // \n
          8'h72: encode_point(32'h0D, ErrNone);  // \r
          8'h74: encode_point(32'h09, ErrNone);  // \t
          8'h76: encode_point(32'h0B, ErrNone);  // \v
          8'h27, 8'h22, 8'h3F, ChBackslash: encode_point({24'd0, b}, ErrNone);
          ChHex2: enter_digits(1'b1, 4'd2, 32'd0);
          ChHex4: enter_digits(1'b1, 4'd4, 32'd0);
          ChHex8: enter_digits(1'b1, 4'd8, 32'd0);
          default: begin
            if (b >= 8'h30 && b <= 8'h37) begin
              enter_digits(1'b0, 4'd2, {29'd0, b[2:0]});
            end else if (!b[7]) begin
              encode_point({24'd0, b}, ErrUnknown);
            end else begin
              // unknown escape on a non-ASCII byte: flag the sequence it starts
              perr_q   = ErrUnknown;
              to_plain = 1'b1;
            end
          end
        endcase
      end
      default: to_plain = 1'b1;
    endcase

    if (to_plain) take_plain(b);

    if (eot) begin
      // flush whatever construct is still open
      if (scan_q == ModeEsc) add_word(8'h00, 1'b0, ErrTrunc);
      else if (scan_q == ModeDigits) encode_point(accum_q, hex_q ? ErrTrunc : ErrNone);
      else if (scan_q == ModeUtf8) encode_point(32'd0, ErrUtf8);
      clear_scan();
      if (burst.size() == 0) add_word(8'h00, 1'b0, ErrNone);
    end

    for (int i = 0; i < burst.size(); i++) begin
      r      = burst[i];
      r.last = (i == burst.size() - 1);
      r.eos  = eot && r.last;
      utf8_words.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_byte(logic [7:0] b, logic eot);
    src_drain.push_back(src_bytes.size() == DrainAt0 || src_bytes.size() == DrainAt1);
    src_bytes.push_back(b);
    src_eot.push_back(eot);
  endtask

  function automatic logic [7:0] hex_char(int v, logic upper);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((upper ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic logic [7:0] simple_escape(int idx);
    case (idx)
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h66;
      3:       return 8'h6E;
      4:       return 8'h72;
      5:       return 8'h74;
      6:       return 8'h76;
      7:       return 8'h27;
      8:       return 8'h22;
      9:       return 8'h3F;
      default: return ChBackslash;
    endcase
  endfunction

  // Build one lexical token of a literal body in tok; mostly well formed
  task automatic build_token();
    int         n;
    logic [7:0] b;
    tok.delete();
    case ($urandom_range(0, 9))
      0, 1: begin
        b = 8'($urandom_range(0, 127));
        if (b == ChBackslash) b = 8'h41;
        tok.push_back(b);
      end
      2: begin
        tok.push_back(ChBackslash);
        tok.push_back(simple_escape($urandom_range(0, 10)));
      end
      3: begin
        tok.push_back(ChBackslash);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) tok.push_back(8'(8'h30 + $urandom_range(0, 7)));
      end
      4: begin
        tok.push_back(ChBackslash);
        case ($urandom_range(0, 2))
          0:       begin tok.push_back(ChHex2); n = 2; end
          1:       begin tok.push_back(ChHex4); n = 4; end
          default: begin tok.push_back(ChHex8); n = 8; end
        endcase
        for (int i = 0; i < n; i++) begin
          // bias the long escapes toward the 21-bit range with leading zeros
          if (n == 8 && i < 3 && $urandom_range(0, 1)) tok.push_back(8'h30);
          else tok.push_back(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
        end
        // now and then cut the digit run short
        if ($urandom_range(0, 5) == 0) tok.delete(tok.size() - 1);
      end
      5: begin
        n = $urandom_range(2, 4);
        case (n)
          2:       tok.push_back(8'(8'hC0 | $urandom_range(0, 31)));
          3:       tok.push_back(8'(8'hE0 | $urandom_range(0, 15)));
          default: tok.push_back(8'(8'hF0 | $urandom_range(0, 7)));
        endcase
        for (int i = 1; i < n; i++) tok.push_back(8'(8'h80 | $urandom_range(0, 63)));
      end
      6: begin
        tok.push_back(ChBackslash);
        tok.push_back(8'($urandom_range(0, 255)));
      end
      7: tok.push_back(8'($urandom_range(0, 255)));
      default: begin
        // broken sequence: lead followed by a non-continuation byte
        tok.push_back(8'(8'hC0 | $urandom_range(0, 63)));
        tok.push_back(8'($urandom_range(0, 1) ? ($urandom_range(0, 127))
                                             : (8'hC0 | $urandom_range(0, 63))));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer the next byte at the falling edge, hold it until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!offering && src_bytes.size() != 0) begin
        go = 1'b1;
        // pause until every owed word has come out
        if (src_drain[0] && utf8_words.size() != 0) go = 1'b0;
        else if (!quiet && $urandom_range(0, 99) < 17) go = 1'b0;
        offering = go;
      end
      in_valid <= offering;
      if (offering) begin
        in_byte        <= src_bytes[0];
        in_end_of_text <= src_eot[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
      end else if (!hold_done && in_count >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldLen;
      end
      out_ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 17);
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_count < PrintCap) begin
      $display("mismatch at output word %0d: %s got %0h want %0h", out_count, what, got, want);
    end
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check result words, predict on accepted bytes, watch for hangs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (utf8_words.size() == 0) begin
          report_mismatch("word with nothing owed, byte", out_byte, 8'h00);
        end else begin
          want_word = utf8_words.pop_front();
          if (out_byte !== want_word.data)
            report_mismatch("out_byte", out_byte, want_word.data);
          if (out_byte_valid !== want_word.valid)
            report_mismatch("out_byte_valid", 8'(out_byte_valid), 8'(want_word.valid));
          if (out_run_last !== want_word.last)
            report_mismatch("out_run_last", 8'(out_run_last), 8'(want_word.last));
          if (out_end_of_string !== want_word.eos)
            report_mismatch("out_end_of_string", 8'(out_end_of_string),
                            8'(want_word.eos));
          if (out_error_code !== want_word.err)
            report_mismatch("out_error_code", 8'(out_error_code), 8'(want_word.err));
        end
        out_count++;
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        predict_word(in_byte, in_end_of_text);
        src_bytes.delete(0);
        src_eot.delete(0);
        src_drain.delete(0);
        offering = 1'b0;
        in_count++;
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("c_string_escape_to_utf8 test failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int   n;
    logic cut;
    logic close;
    clear_scan();

    // Directed string one: extremes of ASCII, a \U escape beyond 21 bits,
    // a short \x escape, and an octal escape still open at end of text
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(ChBackslash, 1'b0);
    add_byte(ChHex8, 1'b0);
    add_byte(8'h46, 1'b0);
    add_byte(8'h66, 1'b0);
    for (int i = 0; i < 6; i++) add_byte(8'h46, 1'b0);
    add_byte(ChBackslash, 1'b0);
    add_byte(ChHex2, 1'b0);
    add_byte(8'h67, 1'b0);
    add_byte(ChBackslash, 1'b0);
    add_byte(8'h37, 1'b1);

    // Directed string two: 4-byte UTF-8, lone continuation, 0xFF lead,
    // interrupted sequence, unknown escapes on UTF-8 and on a digit 9,
    // and a trailing lone backslash
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(8'h98, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(ChBackslash, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(ChBackslash, 1'b0);
    add_byte(8'h39, 1'b0);
    add_byte(ChBackslash, 1'b1);

    // Random strings of random tokens; some close in the middle of a token
    while (src_bytes.size() < 478) begin
      build_token();
      cut = ($urandom_range(0, 11) == 0);
      n = cut ? $urandom_range(1, tok.size()) : tok.size();
      close = cut || ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) add_byte(tok[i], close && (i == n - 1));
    end
    add_byte(8'h5A, 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (src_bytes.size() != 0 || offering) @(posedge clk);
    while (utf8_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("c_string_escape_to_utf8 test passed");
    end else begin
      $display("c_string_escape_to_utf8 test failed");
    end
    $finish;
  end

endmodule
